// ----- rtl/isa_pkg.sv -----
package isa_pkg;

   localparam int DEPTH     = 16;
   localparam int WORD_BITS = 32;
   localparam int CNT_BITS  = $clog2(DEPTH + 1);
   localparam int IDX_BITS  = $clog2(DEPTH);

   localparam logic [2:0] OP_APPEND = 3'd0;
   localparam logic [2:0] OP_REMOVE = 3'd1;
   localparam logic [2:0] OP_INSERT = 3'd2;
   localparam logic [2:0] OP_ERASE  = 3'd3;
   localparam logic [2:0] OP_READ   = 3'd4;
   localparam logic [2:0] OP_WRITE  = 3'd5;
   localparam logic [2:0] OP_CLEAR  = 3'd6;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   typedef logic [WORD_BITS-1:0] word_type;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [4:0]  position;
      logic [31:0] write_value;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [4:0]  entry_count;
      logic [31:0] front_value;
      logic [31:0] back_value;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;

endpackage

// ----- rtl/isa_ctrl.sv -----
module isa_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output logic             rsp_valid,
   output isa_pkg::cmd_type cmd
);
   import isa_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_REPORT
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               rsp_valid_ff <= 1'b0;
               if (start) begin
                  state_ff <= S_EXEC;
                  busy_ff  <= 1'b1;
               end
            end
            S_EXEC: begin
               state_ff     <= S_REPORT;
               rsp_valid_ff <= 1'b1;
            end
            S_REPORT: begin
               state_ff     <= S_IDLE;
               busy_ff      <= 1'b0;
               rsp_valid_ff <= 1'b0;
            end
            default: begin
               state_ff     <= S_IDLE;
               busy_ff      <= 1'b0;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

   assign busy       = busy_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign cmd.load   = start && !busy_ff;
   assign cmd.exec   = (state_ff == S_EXEC);

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after an accepted transaction");

   a_strobe_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("block stayed busy after delivering its result");

endmodule

// ----- rtl/isa_datapath.sv -----
module isa_datapath (
   input  logic             clock,
   input  logic             reset,
   input  isa_pkg::cmd_type cmd,
   input  isa_pkg::req_type req_payload,
   output isa_pkg::rsp_type rsp_payload
);
   import isa_pkg::*;

   logic [2:0]          op_ff;
   logic [4:0]          pos_ff;
   word_type            val_ff;
   word_type            cells_ff [DEPTH];
   word_type            cells_in [DEPTH];
   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] count_in;
   word_type            rd_ff;
   logic [1:0]          st_ff;
   logic [1:0]          st_in;
   logic [CNT_BITS-1:0] count_dec;
   logic [IDX_BITS-1:0] rd_addr;
   word_type            rd_word;
   logic                op_ok;
   logic                op_reads;

   assign count_dec = count_ff - CNT_BITS'(1);

   // One shared read port: the indexed entry while executing any operation but remove, the back entry otherwise.
   always_comb begin
      if (cmd.exec && (op_ff != OP_REMOVE)) begin
         rd_addr = pos_ff[IDX_BITS-1:0];
      end else begin
         rd_addr = count_dec[IDX_BITS-1:0];
      end
   end

   assign rd_word = cells_ff[rd_addr];

   always_comb begin
      st_in    = ST_OK;
      op_reads = 1'b0;
      case (op_ff)
         OP_APPEND: begin
            if (count_ff >= CNT_BITS'(DEPTH)) st_in = ST_FULL;
         end
         OP_REMOVE: begin
            op_reads = 1'b1;
            if (count_ff == '0) st_in = ST_EMPTY;
         end
         OP_INSERT: begin
            if (pos_ff > count_ff) st_in = ST_RANGE;
            else if (count_ff >= CNT_BITS'(DEPTH)) st_in = ST_FULL;
         end
         OP_ERASE, OP_READ: begin
            op_reads = 1'b1;
            if (pos_ff >= count_ff) st_in = ST_RANGE;
         end
         OP_WRITE: begin
            if (pos_ff >= count_ff) st_in = ST_RANGE;
         end
         default: begin
            st_in = ST_OK;
         end
      endcase
   end

   assign op_ok = (st_in == ST_OK);

   // Every cell picks its own next value, so all cells shift together in the execute state.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cells_in[i] = cells_ff[i];
         case (op_ff)
            OP_APPEND: begin
               if (count_ff == CNT_BITS'(i)) cells_in[i] = val_ff;
            end
            OP_INSERT: begin
               if (pos_ff == 5'(i)) begin
                  cells_in[i] = val_ff;
               end else if (i > 0 && pos_ff < 5'(i) && CNT_BITS'(i) <= count_ff) begin
                  cells_in[i] = cells_ff[(i > 0) ? i - 1 : 0];
               end
            end
            OP_ERASE: begin
               if (i < DEPTH - 1 && pos_ff <= 5'(i) && CNT_BITS'(i + 1) < count_ff) begin
                  cells_in[i] = cells_ff[(i < DEPTH - 1) ? i + 1 : i];
               end
            end
            OP_WRITE: begin
               if (pos_ff == 5'(i)) cells_in[i] = val_ff;
            end
            default: begin
               cells_in[i] = cells_ff[i];
            end
         endcase
      end
   end

   always_comb begin
      count_in = count_ff;
      if (op_ok) begin
         case (op_ff)
            OP_APPEND, OP_INSERT: count_in = count_ff + CNT_BITS'(1);
            OP_REMOVE, OP_ERASE:  count_in = count_dec;
            OP_CLEAR:             count_in = '0;
            default:              count_in = count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec && op_ok) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_payload.opcode;
         pos_ff <= req_payload.position;
         val_ff <= req_payload.write_value;
      end
      if (cmd.exec) begin
         st_ff <= st_in;
         rd_ff <= (op_ok && op_reads) ? rd_word : '0;
         if (op_ok) begin
            for (int i = 0; i < DEPTH; i++) begin
               cells_ff[i] <= cells_in[i];
            end
         end
      end
   end

   assign rsp_payload.read_data   = rd_ff;
   assign rsp_payload.entry_count = count_ff;
   assign rsp_payload.front_value = (count_ff != '0) ? cells_ff[0] : '0;
   assign rsp_payload.back_value  = (count_ff != '0) ? rd_word : '0;
   assign rsp_payload.status      = st_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("entry count exceeds capacity");

   a_count_held: assert property (@(posedge clock) disable iff (reset)
      !cmd.exec |=> $stable(count_ff))
      else $error("entry count changed outside execution");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && (op_ff == OP_CLEAR)) |=> (count_ff == '0))
      else $error("clear left entries in the array");

endmodule

// ----- rtl/indexed_shift_array_top.sv -----
// The result of an accepted transaction is computed in the execute state and strobed
// with rsp_valid in the report state; the controller then returns to idle.
// A new transaction is accepted only while idle; busy covers execute and report.
// Execute shifts or writes all sixteen entry cells at once; report reads the back entry.
// Reset (synchronous, active high) empties the array; entry words stay undefined.
// The receiver cannot stall: each result is present for exactly one cycle.
module indexed_shift_array_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  isa_pkg::req_type req_payload,
   output logic             rsp_valid,
   output isa_pkg::rsp_type rsp_payload
);
   import isa_pkg::*;

   cmd_type cmd;

   isa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   isa_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- bench/tb_indexed_shift_array_top.sv -----
module tb_indexed_shift_array_top;
   import isa_pkg::*;

   localparam logic [2:0] OP_NOOP     = 3'd7;
   localparam int         CYCLE_LIMIT = 100000;
   localparam int         RANDOM_OPS  = 400;
   localparam int         SHOW_LIMIT  = 10;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_payload;
   logic    rsp_valid;
   rsp_type rsp_payload;

   indexed_shift_array_top u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   // Shadow copy of the array contents and occupancy.
   word_type shadow_cells [DEPTH];
   int       shadow_count;
   int       peak_count;

   rsp_type  pending_results [$];
   int       sent_count;
   int       checked_count;
   int       error_count;
   int       cycle_count;
   int       status_hits [4];
   bit       steady_stream;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_results.size());
         $display("tb_indexed_shift_array_top NOT OK");
         $finish;
      end
   end

   function automatic rsp_type predict_array_op(input req_type r);
      rsp_type res;
      int      p;
      int      i;
      res = '0;
      res.status = ST_OK;
      p = r.position;
      case (r.opcode)
         OP_APPEND: begin
            if (shadow_count >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               shadow_cells[shadow_count] = r.write_value;
               shadow_count++;
            end
         end
         OP_REMOVE: begin
            if (shadow_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               shadow_count--;
               res.read_data = shadow_cells[shadow_count];
            end
         end
         OP_INSERT: begin
            // The range check takes precedence over the full check.
            if (p > shadow_count) begin
               res.status = ST_RANGE;
            end else if (shadow_count >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               for (i = shadow_count; i > p; i--) shadow_cells[i] = shadow_cells[i-1];
               shadow_cells[p] = r.write_value;
               shadow_count++;
            end
         end
         OP_ERASE: begin
            if (p >= shadow_count) begin
               res.status = ST_RANGE;
            end else begin
               res.read_data = shadow_cells[p];
               for (i = p; i + 1 < shadow_count; i++) shadow_cells[i] = shadow_cells[i+1];
               shadow_count--;
            end
         end
         OP_READ: begin
            if (p >= shadow_count) res.status = ST_RANGE;
            else res.read_data = shadow_cells[p];
         end
         OP_WRITE: begin
            if (p >= shadow_count) res.status = ST_RANGE;
            else shadow_cells[p] = r.write_value;
         end
         OP_CLEAR: begin
            shadow_count = 0;
         end
         default: begin
         end
      endcase
      res.entry_count = shadow_count[4:0];
      if (shadow_count > 0) begin
         res.front_value = shadow_cells[0];
         res.back_value  = shadow_cells[shadow_count-1];
      end
      if (shadow_count > peak_count) peak_count = shadow_count;
      status_hits[res.status]++;
      return res;
   endfunction

   function automatic word_type pick_word();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return '0;
      if (sel == 1) return '1;
      return $urandom;
   endfunction

   task automatic send_op(input logic [2:0] op, input logic [4:0] pos, input word_type val);
      req_type r;
      rsp_type predicted;
      int      gap;
      r.opcode      = op;
      r.position    = pos;
      r.write_value = val;
      gap = steady_stream ? 0 : $urandom_range(0, 7);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start       <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      predicted = predict_array_op(r);
      pending_results = {pending_results, predicted};
      sent_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= SHOW_LIMIT)
               $display("unexpected result: data %h count %0d front %h back %h status %0d",
                        rsp_payload.read_data, rsp_payload.entry_count,
                        rsp_payload.front_value, rsp_payload.back_value, rsp_payload.status);
         end else begin
            want = pending_results.pop_front();
            checked_count++;
            if (rsp_payload.read_data   !== want.read_data   ||
                rsp_payload.entry_count !== want.entry_count ||
                rsp_payload.front_value !== want.front_value ||
                rsp_payload.back_value  !== want.back_value  ||
                rsp_payload.status      !== want.status) begin
               error_count++;
               if (error_count <= SHOW_LIMIT) begin
                  $display("mismatch on result %0d", checked_count);
                  $display("  expected data %h count %0d front %h back %h status %0d",
                           want.read_data, want.entry_count, want.front_value,
                           want.back_value, want.status);
                  $display("  actual   data %h count %0d front %h back %h status %0d",
                           rsp_payload.read_data, rsp_payload.entry_count,
                           rsp_payload.front_value, rsp_payload.back_value,
                           rsp_payload.status);
               end
            end
         end
      end
   end

   task automatic reset_dut();
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      shadow_count = 0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
   endtask

   // Every operation that can be refused on an empty array, plus clear and the spare opcode.
   task automatic test_empty_array();
      send_op(OP_REMOVE, 5'd0, '1);
      send_op(OP_ERASE, 5'd0, '0);
      send_op(OP_READ, 5'd0, '0);
      send_op(OP_WRITE, 5'd0, '1);
      send_op(OP_CLEAR, 5'd0, '0);
      send_op(OP_NOOP, 5'd31, '1);
   endtask

   // Grow to capacity through appends and inserts at the front, middle and end,
   // then check that growth is refused and that the range check wins over full.
   task automatic test_fill_to_capacity();
      int k;
      send_op(OP_APPEND, 5'd0, '0);
      send_op(OP_APPEND, 5'd0, '1);
      for (k = 0; k < 11; k++) send_op(OP_APPEND, 5'(k), pick_word());
      send_op(OP_INSERT, 5'd0, 32'hA5A5_5A5A);
      send_op(OP_INSERT, 5'd7, 32'h8000_0001);
      send_op(OP_INSERT, 5'd15, 32'h7FFF_FFFE);
      send_op(OP_APPEND, 5'd0, '1);
      send_op(OP_INSERT, 5'd16, '1);
      send_op(OP_INSERT, 5'd31, '0);
      send_op(OP_CLEAR, 5'd16, '1);
   endtask

   // Random mix that alternates between growing and shrinking the array, with
   // mostly legal positions and some arbitrary ones.
   task automatic test_random_mix();
      int          n;
      int          sel;
      bit          grow;
      logic [2:0]  op;
      logic [4:0]  pos;
      grow = 1'b1;
      for (n = 0; n < RANDOM_OPS; n++) begin
         if (n % 50 == 0) grow = ~grow;
         if (n % 40 == 0) steady_stream = ($urandom_range(0, 2) == 0);
         sel = $urandom_range(0, 99);
         if (sel < 35)      op = grow ? OP_APPEND : OP_REMOVE;
         else if (sel < 60) op = grow ? OP_INSERT : OP_ERASE;
         else if (sel < 68) op = grow ? OP_REMOVE : OP_APPEND;
         else if (sel < 76) op = grow ? OP_ERASE : OP_INSERT;
         else if (sel < 86) op = OP_READ;
         else if (sel < 96) op = OP_WRITE;
         else if (sel < 98) op = OP_CLEAR;
         else               op = OP_NOOP;
         if ($urandom_range(0, 4) == 0) begin
            pos = 5'($urandom_range(0, 31));
         end else if (op == OP_INSERT) begin
            pos = 5'($urandom_range(0, shadow_count));
         end else begin
            pos = (shadow_count == 0) ? 5'd0 : 5'($urandom_range(0, shadow_count - 1));
         end
         send_op(op, pos, pick_word());
      end
      steady_stream = 1'b0;
   endtask

   initial begin
      sent_count    = 0;
      checked_count = 0;
      error_count   = 0;
      cycle_count   = 0;
      peak_count    = 0;
      steady_stream = 1'b0;
      status_hits   = '{default: 0};
      reset_dut();
      test_empty_array();
      test_fill_to_capacity();
      test_random_mix();
      @(negedge clock);
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      $display("%0d transactions sent, %0d results checked, peak occupancy %0d of %0d",
               sent_count, checked_count, peak_count, DEPTH);
      $display("statuses: ok %0d, range %0d, empty %0d, full %0d; %0d mismatches",
               status_hits[ST_OK], status_hits[ST_RANGE], status_hits[ST_EMPTY],
               status_hits[ST_FULL], error_count);
      if (error_count == 0) begin
         $display("tb_indexed_shift_array_top OK");
      end else begin
         $display("tb_indexed_shift_array_top NOT OK");
      end
      $finish;
   end

endmodule
